// File: design/sliding_window_ack_tracker_assert.svh
// Assertion macros used by the checker file of the window tracker.
`ifndef SLIDING_WINDOW_ACK_TRACKER_ASSERT_SVH
`define SLIDING_WINDOW_ACK_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWAT_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swat_checker: property violated");

// Consequent must hold in the cycle after the antecedent.
`define SWAT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swat_checker: property violated");

`endif

// File: design/swat_pkg.sv
`timescale 1ns / 1ps

package swat_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 16;
    localparam int SEQ_W = 32;
    localparam int CNT_W = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0] RESET_WINDOW_SIZE = 5'd10;

    localparam logic ADDR_WINDOW_SIZE = 1'b0;

    typedef struct packed {
        logic shift;
        logic set;
    } t_cell_ctl;

endpackage

// File: design/sliding_window_ack_tracker.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Word
// ack       in         i_ack_valid / o_ack_ready     i_ack_seq
// result    out        o_res_valid / i_res_ready     window bounds, counts, match flag
// config    in         psel / penable / pwrite       window_size at paddr 0
//
// After an ack word is accepted, the bit chain shifts one slot per cycle, once per slot released,
// and the result is registered once the front slot is clear and the output register is free.
// The ack channel is ready only between words; a finished result waits in the
// output register and the next ack word may be accepted meanwhile.
// Reset is synchronous and active low and needs no clearing pass.

module sliding_window_ack_tracker
    import swat_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_ack_valid,
    output logic               o_ack_ready,
    input  logic [SEQ_W-1:0]   i_ack_seq,

    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [SEQ_W-1:0]   o_window_base,
    output logic [SEQ_W-1:0]   o_next_sequence,
    output logic [CNT_W-1:0]   o_released_count,
    output logic [CNT_W-1:0]   o_added_count,
    output logic               o_ack_matched,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int TW = (CW > CNT_W) ? CW : CNT_W;
    localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [TW-1:0] DEPTH_T = TW'(WINDOW_DEPTH);
    localparam logic [TW-1:0] RESET_LEN =
        (TW'(RESET_WINDOW_SIZE) > DEPTH_T) ? DEPTH_T : TW'(RESET_WINDOW_SIZE);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_ws;
    logic [SEQ_W-1:0] r_base;
    logic [SEQ_W-1:0] r_next;
    logic [TW-1:0]    r_len;
    logic [TW-1:0]    r_released;
    logic             r_match;

    logic             r_out_valid;
    logic [SEQ_W-1:0] r_out_base;
    logic [SEQ_W-1:0] r_out_next;
    logic [CNT_W-1:0] r_out_rel;
    logic [CNT_W-1:0] r_out_add;
    logic             r_out_match;

    logic             w_accept;
    logic             w_cfg_wr;
    logic [SEQ_W-1:0] w_off;
    logic             w_hit;
    logic             w_front;
    logic             w_shift;
    logic             w_finish;
    logic [TW-1:0]    w_target;
    logic [TW-1:0]    w_remain;
    logic [TW-1:0]    w_added;
    t_cell_ctl        w_ctl [WINDOW_DEPTH];

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == ADDR_WINDOW_SIZE);
    assign prdata      = (paddr[2] == ADDR_WINDOW_SIZE) ? PDATA_W'(r_ws) : '0;

    assign o_ack_ready = (r_state == ST_IDLE);
    assign w_accept    = i_ack_valid && o_ack_ready;

    assign w_off    = i_ack_seq - r_base;
    assign w_hit    = (w_off < SEQ_W'(r_len));
    assign w_shift  = (r_state == ST_SCAN) && w_front;
    assign w_finish = (r_state == ST_SCAN) && !w_front && (!r_out_valid || i_res_ready);

    assign w_target = (TW'(r_ws) > DEPTH_T) ? DEPTH_T : TW'(r_ws);
    assign w_remain = r_len - r_released;
    assign w_added  = ((r_released != '0) && (w_remain < w_target)) ?
                      (w_target - w_remain) : '0;

    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_ctl
        assign w_ctl[i].shift = w_shift;
        assign w_ctl[i].set   = w_accept && w_hit && (w_off[IW-1:0] == IW'(i));
    end

    swat_chain #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_front (w_front)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ws        <= RESET_WINDOW_SIZE;
            r_base      <= SEQ_W'(1);
            r_next      <= SEQ_W'(1) + SEQ_W'(RESET_LEN);
            r_len       <= RESET_LEN;
            r_released  <= '0;
            r_match     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_ws <= pwdata[CNT_W-1:0];
            end
            if (w_accept) begin
                r_match    <= w_hit;
                r_released <= '0;
            end
            if (w_shift) begin
                r_base     <= r_base + SEQ_W'(1);
                r_released <= r_released + TW'(1);
            end
            if (w_finish) begin
                r_next      <= r_next + SEQ_W'(w_added);
                r_len       <= w_remain + w_added;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_base  <= r_base;
            r_out_next  <= r_next + SEQ_W'(w_added);
            r_out_rel   <= r_released[CNT_W-1:0];
            r_out_add   <= w_added[CNT_W-1:0];
            r_out_match <= r_match;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_window_base    = r_out_base;
    assign o_next_sequence  = r_out_next;
    assign o_released_count = r_out_rel;
    assign o_added_count    = r_out_add;
    assign o_ack_matched    = r_out_match;

endmodule

// File: design/swat_cell.sv
`timescale 1ns / 1ps

module swat_cell
    import swat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_next,
    output logic      o_bit
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.shift) begin
            r_bit <= i_next;
        end else begin
            r_bit <= r_bit | i_ctl.set;
        end
    end

    assign o_bit = r_bit;

endmodule

// File: design/swat_chain.sv
`timescale 1ns / 1ps

module swat_chain
    import swat_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl [WINDOW_DEPTH],
    output logic      o_front
);

    logic w_bit  [WINDOW_DEPTH];
    logic w_next [WINDOW_DEPTH];

    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
        if (i == WINDOW_DEPTH - 1) begin : g_last
            assign w_next[i] = 1'b0;
        end else begin : g_mid
            assign w_next[i] = w_bit[i+1];
        end

        swat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl[i]),
            .i_next  (w_next[i]),
            .o_bit   (w_bit[i])
        );
    end

    assign o_front = w_bit[0];

endmodule

// File: design/swat_checker.sv
`timescale 1ns / 1ps

`include "sliding_window_ack_tracker_assert.svh"

module swat_checker
    import swat_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             o_res_valid,
    input  logic             i_res_ready,
    input  logic [SEQ_W-1:0] o_window_base,
    input  logic [SEQ_W-1:0] o_next_sequence,
    input  logic [CNT_W-1:0] o_released_count,
    input  logic [CNT_W-1:0] o_added_count,
    input  logic             o_ack_matched
);

    `SWAT_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid)

    `SWAT_ASSERT_SAME(a_window_len, i_clk, i_rst_n, o_res_valid, (o_next_sequence - o_window_base) <= SEQ_W'(WINDOW_DEPTH))

    `SWAT_ASSERT_SAME(a_miss_no_change, i_clk, i_rst_n, o_res_valid && !o_ack_matched, (o_released_count == '0) && (o_added_count == '0))

    `SWAT_ASSERT_SAME(a_add_needs_release, i_clk, i_rst_n, o_res_valid && (o_added_count != '0), o_released_count != '0)

endmodule

bind sliding_window_ack_tracker swat_checker #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_swat_checker (.*);

// File: tb/tb_sliding_window_ack_tracker.sv
`timescale 1ns / 1ps

module tb_sliding_window_ack_tracker;
    import swat_pkg::*;

    localparam int DEPTH = DEFAULT_WINDOW_DEPTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int PHASES = 8;

    typedef struct {
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] nxt_seq;
        logic [CNT_W-1:0] released;
        logic [CNT_W-1:0] added;
        logic             matched;
    } t_window_word;

    typedef struct {
        logic [SEQ_W-1:0] ack;
        bit               typed;
        t_window_word     want;
    } t_script_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_ack_valid = 1'b0;
    logic               o_ack_ready;
    logic [SEQ_W-1:0]   i_ack_seq = '0;
    logic               o_res_valid;
    logic               i_res_ready = 1'b0;
    logic [SEQ_W-1:0]   o_window_base;
    logic [SEQ_W-1:0]   o_next_sequence;
    logic [CNT_W-1:0]   o_released_count;
    logic [CNT_W-1:0]   o_added_count;
    logic               o_ack_matched;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic [SEQ_W-1:0] model_base;
    logic [SEQ_W-1:0] model_next;
    logic [DEPTH-1:0] model_acked;
    logic [CNT_W-1:0] model_size;

    t_window_word expected_windows[$];
    t_script_row  ack_script[$];
    t_window_word no_want;
    int           phase_sizes[PHASES] = '{16, 1, 31, 5, 16, 3, 12, 0};
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_left = 0;
    bit           hold_req = 1'b0;

    sliding_window_ack_tracker u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ack_valid      (i_ack_valid),
        .o_ack_ready      (o_ack_ready),
        .i_ack_seq        (i_ack_seq),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_window_base    (o_window_base),
        .o_next_sequence  (o_next_sequence),
        .o_released_count (o_released_count),
        .o_added_count    (o_added_count),
        .o_ack_matched    (o_ack_matched),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_window_word track_ack(input logic [SEQ_W-1:0] ack);
        t_window_word w;
        logic [SEQ_W-1:0] span;
        logic [SEQ_W-1:0] off;
        int unsigned target;
        int unsigned rel;
        int unsigned remain;
        int unsigned add_n;
        span = model_next - model_base;
        if (span > DEPTH) span = DEPTH;
        target = (model_size > DEPTH) ? DEPTH : model_size;
        off = ack - model_base;
        w.matched = (off < span);
        if (w.matched) model_acked[off] = 1'b1;
        rel = 0;
        while (rel < span && model_acked[rel]) rel++;
        model_acked = model_acked >> rel;
        remain = span - rel;
        add_n = (rel > 0 && remain < target) ? target - remain : 0;
        model_base = model_base + rel;
        model_next = model_next + add_n;
        w.base = model_base;
        w.nxt_seq = model_next;
        w.released = CNT_W'(rel);
        w.added = CNT_W'(add_n);
        return w;
    endfunction

    function automatic void expect_word(input t_window_word w);
        expected_windows.insert(expected_windows.size(), w);
    endfunction

    function automatic t_window_word take_expected();
        t_window_word w;
        w = expected_windows[0];
        expected_windows.delete(0);
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [SEQ_W-1:0] want,
                                        input logic [SEQ_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic script_row(input logic [SEQ_W-1:0] ack, input bit typed,
                              input logic [SEQ_W-1:0] base, input logic [SEQ_W-1:0] nxt,
                              input int rel, input int add_n, input bit m);
        t_script_row row;
        row.ack = ack;
        row.typed = typed;
        row.want.base = base;
        row.want.nxt_seq = nxt;
        row.want.released = CNT_W'(rel);
        row.want.added = CNT_W'(add_n);
        row.want.matched = m;
        ack_script.insert(ack_script.size(), row);
    endtask

    task automatic send_ack(input logic [SEQ_W-1:0] ack, input bit typed,
                            input t_window_word want);
        t_window_word w;
        while ($urandom_range(99) < send_idle_pct) begin
            i_ack_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_ack_valid <= 1'b1;
        i_ack_seq <= ack;
        do @(posedge i_clk); while (!o_ack_ready);
        w = track_ack(ack);
        expect_word(typed ? want : w);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [CNT_W-1:0] size);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(ADDR_WINDOW_SIZE);
        pwdata <= (PDATA_W'($urandom) & ~PDATA_W'({CNT_W{1'b1}})) | PDATA_W'(size);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        model_size = size;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apb_read_check(input logic [CNT_W-1:0] size);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PADDR_W'(ADDR_WINDOW_SIZE);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("window_size", SEQ_W'(size), SEQ_W'(prdata));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            i_res_ready <= 1'b0;
            hold_left--;
        end else begin
            i_res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_window_word want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_windows.size() == 0) begin
                $error("result word with none expected: window_base %0h", o_window_base);
                mismatches++;
            end else begin
                want = take_expected();
                check_field("window_base", want.base, o_window_base);
                check_field("next_sequence", want.nxt_seq, o_next_sequence);
                check_field("released_count", SEQ_W'(want.released), SEQ_W'(o_released_count));
                check_field("added_count", SEQ_W'(want.added), SEQ_W'(o_added_count));
                check_field("ack_matched", SEQ_W'(want.matched), SEQ_W'(o_ack_matched));
            end
        end
    end

    initial begin : stimulus
        logic [SEQ_W-1:0] ack;
        logic [SEQ_W-1:0] span;
        int unsigned      pick;
        int unsigned      sweep_left;

        model_size = RESET_WINDOW_SIZE;
        model_base = 1;
        model_next = 1 + ((RESET_WINDOW_SIZE > DEPTH) ? DEPTH : RESET_WINDOW_SIZE);
        model_acked = '0;
        no_want = '{default: '0};
        sweep_left = 0;

        // A repeated ack to a set slot still matches, and acks just outside
        // the window on either side miss.
        script_row(32'd0, 1, 1, 11, 0, 0, 0);
        script_row(32'd11, 1, 1, 11, 0, 0, 0);
        script_row(32'hFFFF_FFFF, 1, 1, 11, 0, 0, 0);
        script_row(32'd10, 1, 1, 11, 0, 0, 1);
        script_row(32'd10, 1, 1, 11, 0, 0, 1);
        script_row(32'd1, 1, 2, 12, 1, 1, 1);
        for (int s = 3; s <= 9; s++) script_row(s, 0, 0, 0, 0, 0, 0);
        script_row(32'd2, 1, 11, 21, 9, 9, 1);
        script_row(32'h8000_0000, 1, 11, 21, 0, 0, 0);
        script_row(32'h7FFF_FFFF, 1, 11, 21, 0, 0, 0);
        script_row(32'h5555_5555, 1, 11, 21, 0, 0, 0);
        script_row(32'hAAAA_AAAA, 1, 11, 21, 0, 0, 0);
        script_row(32'd20, 1, 11, 21, 0, 0, 1);
        script_row(32'd12, 0, 0, 0, 0, 0, 0);
        script_row(32'd11, 1, 13, 23, 2, 2, 1);
        script_row(32'd10, 0, 0, 0, 0, 0, 0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apb_read_check(RESET_WINDOW_SIZE);

        send_idle_pct = 35;
        recv_idle_pct = 85;
        foreach (ack_script[i]) begin
            send_ack(ack_script[i].ack, ack_script[i].typed, ack_script[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            i_ack_valid <= 1'b0;
            while (expected_windows.size() != 0) @(posedge i_clk);
            @(negedge i_clk);
            apb_write(CNT_W'(phase_sizes[phase]));
            apb_read_check(CNT_W'(phase_sizes[phase]));
            if (phase < 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 85;
            end else if (phase < 6) begin
                send_idle_pct = 85;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 1 || phase == 4) hold_req = 1'b1;
            sweep_left = 0;
            repeat (ITEMS_PER_PHASE) begin
                span = model_next - model_base;
                if (sweep_left == 0 && span > 1 && $urandom_range(99) < 4) sweep_left = span;
                pick = $urandom_range(99);
                if (sweep_left > 0) begin
                    ack = model_base + sweep_left - 1;
                    sweep_left--;
                end else if (span != 0 && pick < 25) begin
                    ack = model_base;
                end else if (span != 0 && pick < 75) begin
                    ack = model_base + $urandom_range(span - 1);
                end else if (pick < 82) begin
                    ack = model_next;
                end else if (pick < 88) begin
                    ack = model_base - 1;
                end else if (pick < 93) begin
                    ack = model_next + $urandom_range(40);
                end else begin
                    ack = $urandom;
                end
                send_ack(ack, 0, no_want);
            end
        end

        i_ack_valid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/swat_pkg.sv
design/swat_cell.sv
design/swat_chain.sv
design/sliding_window_ack_tracker.sv
design/swat_checker.sv
tb/tb_sliding_window_ack_tracker.sv
